// ===== rtl/core/pdsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdsp_pkg
// Shared types, codes and helpers for the property definition stream parser.
// ----------------------------------------------------------------------------
package pdsp_pkg;

    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_VERSION_TWO = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_DEFS    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_SKIPS   = 2'd2;

    localparam logic [15:0] RST_VERSION_TWO = 16'd259;
    localparam logic [15:0] RST_MAX_DEFS    = 16'd1000;
    localparam logic [15:0] RST_MAX_SKIPS   = 16'd500;

    localparam logic [7:0]  ESCAPE_BYTE  = 8'hFF;
    localparam logic [2:0]  LAST_STRING  = 3'd4;
    localparam logic [3:0]  KIND_IGNORED = 4'd13;

    localparam logic [1:0]  STAT_OK       = 2'd0;
    localparam logic [1:0]  STAT_BAD_CNT  = 2'd1;
    localparam logic [1:0]  STAT_SKIP_OVF = 2'd2;

    typedef enum logic [3:0] {
        PH_VERSION   = 4'd0,
        PH_COUNT     = 4'd1,
        PH_FLAGS     = 4'd2,
        PH_VARTYPE   = 4'd3,
        PH_DISPID    = 4'd4,
        PH_NAMELEN   = 4'd5,
        PH_NAMECHARS = 4'd6,
        PH_STRLEN    = 4'd7,
        PH_EXTLEN    = 4'd8,
        PH_STRCHARS  = 4'd9,
        PH_INTTYPE   = 4'd10,
        PH_SKIPSIZE  = 4'd11,
        PH_SKIPDATA  = 4'd12,
        PH_DONE_OK   = 4'd13,
        PH_DONE_BAD  = 4'd14,
        PH_DONE_OVF  = 4'd15
    } t_phase;

    typedef struct packed {
        logic [15:0] version_two_code;
        logic [15:0] max_definitions;
        logic [15:0] max_skip_blocks;
    } t_cfg;

    typedef struct packed {
        logic [3:0]  field_kind;
        logic [15:0] def_index;
        logic [2:0]  string_number;
        logic [31:0] field_value;
        logic        value_done;
        logic [1:0]  status;
    } t_result;

    // bytes in a numeric field, zero for the others
    function automatic logic [2:0] field_bytes(input t_phase ph);
        logic [2:0] nb;
        unique case (ph)
            PH_VERSION, PH_VARTYPE, PH_NAMELEN, PH_EXTLEN:         nb = 3'd2;
            PH_COUNT, PH_FLAGS, PH_DISPID, PH_INTTYPE, PH_SKIPSIZE: nb = 3'd4;
            PH_STRLEN:                                              nb = 3'd1;
            default:                                                nb = 3'd0;
        endcase
        return nb;
    endfunction

endpackage

// ===== rtl/core/pdsp_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdsp_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module pdsp_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pdsp_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [pdsp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output pdsp_pkg::t_cfg                   o_cfg
);
    import pdsp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.version_two_code <= RST_VERSION_TWO;
            r_cfg.max_definitions  <= RST_MAX_DEFS;
            r_cfg.max_skip_blocks  <= RST_MAX_SKIPS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_VERSION_TWO: r_cfg.version_two_code <= i_cfg_data;
                CFG_MAX_DEFS:    r_cfg.max_definitions  <= i_cfg_data;
                CFG_MAX_SKIPS:   r_cfg.max_skip_blocks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/pdsp_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdsp_parser
// Parse state and one-byte step: tags the byte and assembles numeric fields.
// ----------------------------------------------------------------------------
module pdsp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pdsp_pkg::t_cfg    i_cfg,
    input  logic              i_step_en,
    input  logic [7:0]        i_byte,
    input  logic              i_first,
    output pdsp_pkg::t_result o_res
);
    import pdsp_pkg::*;

    t_phase      r_phase,  n_phase;
    logic [1:0]  r_bif,    n_bif;
    logic [23:0] r_acc,    n_acc;
    logic [31:0] r_rem,    n_rem;
    logic [15:0] r_ver,    n_ver;
    logic [15:0] r_left,   n_left;
    logic [15:0] r_def,    n_def;
    logic [2:0]  r_str,    n_str;
    logic [15:0] r_seen,   n_seen;

    t_phase      c_phase;
    logic [1:0]  c_bif;
    logic [23:0] c_acc;
    logic [31:0] c_rem;
    logic [15:0] c_ver;
    logic [15:0] c_left;
    logic [15:0] c_def;
    logic [2:0]  c_str;
    logic [15:0] c_seen;
    logic [2:0]  nb;
    logic [31:0] val_full;
    logic [31:0] start_len;
    logic [15:0] seen_inc;
    logic        start_chars;
    logic        end_str;
    logic        end_def;

    always_comb begin
        // restart takes the byte as the first version byte
        c_phase = i_first ? PH_VERSION : r_phase;
        c_bif   = i_first ? 2'd0  : r_bif;
        c_acc   = i_first ? 24'd0 : r_acc;
        c_rem   = i_first ? 32'd0 : r_rem;
        c_ver   = i_first ? 16'd0 : r_ver;
        c_left  = i_first ? 16'd0 : r_left;
        c_def   = i_first ? 16'd0 : r_def;
        c_str   = i_first ? 3'd0  : r_str;
        c_seen  = i_first ? 16'd0 : r_seen;

        n_phase = c_phase;
        n_bif   = c_bif;
        n_acc   = c_acc;
        n_rem   = c_rem;
        n_ver   = c_ver;
        n_left  = c_left;
        n_def   = c_def;
        n_str   = c_str;
        n_seen  = c_seen;

        start_chars = 1'b0;
        start_len   = 32'd0;
        end_str     = 1'b0;
        end_def     = 1'b0;
        seen_inc    = (c_seen != 16'hFFFF) ? c_seen + 16'd1 : c_seen;

        o_res.field_kind    = (c_phase >= PH_DONE_OK) ? KIND_IGNORED : 4'(c_phase);
        o_res.def_index     = (c_phase >= PH_FLAGS && c_phase <= PH_SKIPDATA) ? c_def : 16'd0;
        o_res.string_number = (c_phase >= PH_STRLEN && c_phase <= PH_STRCHARS) ? c_str : 3'd0;
        o_res.field_value   = 32'd0;
        o_res.value_done    = 1'b0;

        nb       = field_bytes(c_phase);
        val_full = {8'd0, c_acc} | ({24'd0, i_byte} << {c_bif, 3'b000});

        if (nb != 3'd0) begin
            if ({1'b0, c_bif} + 3'd1 >= nb) begin
                o_res.field_value = val_full;
                o_res.value_done  = 1'b1;
                n_bif = 2'd0;
                n_acc = 24'd0;
                unique case (c_phase)
                    PH_VERSION: begin
                        n_ver   = val_full[15:0];
                        n_phase = PH_COUNT;
                    end
                    PH_COUNT: begin
                        n_left = val_full[15:0];
                        n_def  = 16'd0;
                        if (val_full == 32'd0 || val_full >= {16'd0, i_cfg.max_definitions}) begin
                            n_phase = PH_DONE_BAD;
                        end else begin
                            n_phase = PH_FLAGS;
                        end
                    end
                    PH_FLAGS:   n_phase = PH_VARTYPE;
                    PH_VARTYPE: n_phase = PH_DISPID;
                    PH_DISPID:  n_phase = PH_NAMELEN;
                    PH_NAMELEN: begin
                        n_rem   = {15'd0, val_full[15:0], 1'b0};
                        n_str   = 3'd0;
                        n_phase = (val_full[15:0] == 16'd0) ? PH_STRLEN : PH_NAMECHARS;
                    end
                    PH_STRLEN: begin
                        if (val_full[7:0] == ESCAPE_BYTE) begin
                            n_phase = PH_EXTLEN;
                        end else begin
                            start_chars = 1'b1;
                            start_len   = {24'd0, val_full[7:0]};
                        end
                    end
                    PH_EXTLEN: begin
                        start_chars = 1'b1;
                        start_len   = {16'd0, val_full[15:0]};
                    end
                    PH_INTTYPE: begin
                        n_seen  = 16'd0;
                        n_phase = PH_SKIPSIZE;
                    end
                    default: begin
                        n_seen = seen_inc;
                        if (seen_inc >= i_cfg.max_skip_blocks) begin
                            n_phase = PH_DONE_OVF;
                        end else if (val_full == 32'd0) begin
                            end_def = 1'b1;
                        end else begin
                            n_rem   = val_full;
                            n_phase = PH_SKIPDATA;
                        end
                    end
                endcase
            end else begin
                n_bif = c_bif + 2'd1;
                n_acc = val_full[23:0];
            end
        end else if (c_phase == PH_NAMECHARS || c_phase == PH_STRCHARS
                     || c_phase == PH_SKIPDATA) begin
            n_rem = c_rem - 32'd1;
            if (c_rem == 32'd1) begin
                priority if (c_phase == PH_NAMECHARS) begin
                    n_str   = 3'd0;
                    n_phase = PH_STRLEN;
                end else if (c_phase == PH_STRCHARS) begin
                    end_str = 1'b1;
                end else begin
                    n_phase = PH_SKIPSIZE;
                end
            end
        end

        if (start_chars) begin
            n_rem = start_len;
            if (start_len == 32'd0) begin
                end_str = 1'b1;
            end else begin
                n_phase = PH_STRCHARS;
            end
        end

        if (end_str) begin
            priority if (c_str < LAST_STRING) begin
                n_str   = c_str + 3'd1;
                n_phase = PH_STRLEN;
            end else if (c_ver == i_cfg.version_two_code) begin
                n_phase = PH_INTTYPE;
            end else begin
                end_def = 1'b1;
            end
        end

        if (end_def) begin
            n_left  = c_left - 16'd1;
            n_def   = c_def + 16'd1;
            n_str   = 3'd0;
            n_phase = (c_left == 16'd1) ? PH_DONE_OK : PH_FLAGS;
        end

        priority if (n_phase == PH_DONE_BAD) begin
            o_res.status = STAT_BAD_CNT;
        end else if (n_phase == PH_DONE_OVF) begin
            o_res.status = STAT_SKIP_OVF;
        end else begin
            o_res.status = STAT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_VERSION;
            r_bif   <= 2'd0;
            r_acc   <= 24'd0;
            r_rem   <= 32'd0;
            r_ver   <= 16'd0;
            r_left  <= 16'd0;
            r_def   <= 16'd0;
            r_str   <= 3'd0;
            r_seen  <= 16'd0;
        end else if (i_step_en) begin
            r_phase <= n_phase;
            r_bif   <= n_bif;
            r_acc   <= n_acc;
            r_rem   <= n_rem;
            r_ver   <= n_ver;
            r_left  <= n_left;
            r_def   <= n_def;
            r_str   <= n_str;
            r_seen  <= n_seen;
        end
    end

endmodule

// ===== rtl/core/property_definition_stream_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// property_definition_stream_parser_unit
// Byte-wise property definition stream parser with field tagging.
// ----------------------------------------------------------------------------
// path: an accepted word goes to the input register, then through the parse
// step to the result register, where it stays while held by the sink
// throughput: one word per cycle unless the sink holds the result register;
// the parse step lies between the input register and the result register
// reset: synchronous active low; parse restarts at the version field and
// the configuration registers return to their defaults
module property_definition_stream_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // stream_byte
    input  logic        s_axis_tuser,   // first_of_stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // def_index[15:0], string_number[18:16], field_value[50:19],
    // status[52:51], zero fill[55:53]
    output logic [55:0] m_axis_tdata,
    output logic [4:0]  m_axis_tuser    // field_kind[3:0], value_done[4]
);
    import pdsp_pkg::*;

    t_cfg       cfg;
    t_result    step_res;
    t_result    r_out;
    logic       r_out_valid;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_first;
    logic       out_free;
    logic       step_en;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign step_en       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    pdsp_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    pdsp_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_step_en (step_en),
        .i_byte    (r_in_byte),
        .i_first   (r_in_first),
        .o_res     (step_res)
    );

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_first <= s_axis_tuser;
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_en) begin
            r_out <= step_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.status, r_out.field_value,
                            r_out.string_number, r_out.def_index};
    assign m_axis_tuser  = {r_out.value_done, r_out.field_kind};

endmodule
